/* rtl/core/time_sorted_event_table_macros.svh */
// ----------------------------------------------------------------------------
// time_sorted_event_table_macros.svh
// Assertion macros for the event table checker.
// ----------------------------------------------------------------------------
`ifndef TIME_SORTED_EVENT_TABLE_MACROS_SVH
`define TIME_SORTED_EVENT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, held off while rst_n is low.
`define TSET_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off while rst_n is low.
`define TSET_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tset_pkg.sv */
// ----------------------------------------------------------------------------
// tset_pkg
// Types, widths and codes shared by the time sorted event table.
// ----------------------------------------------------------------------------
package tset_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int CMD_W    = 2;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int TAG_W    = 16;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int TOTAL_W  = 5;
    localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [TAG_W-1:0]    tag;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } cell_op_t;

    // Broadcast to every cell in the row.
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

    // Per-cell position flags, derived from the count and the delete index.
    typedef struct packed {
        logic occupied;
        logic tail;
        logic del_shift;
    } cell_flags_t;

    // True when time a is strictly later than time b.
    function automatic logic later(entry_t a, entry_t b);
        later = (a.hour > b.hour) || ((a.hour == b.hour) && (a.minute > b.minute));
    endfunction

endpackage

/* rtl/core/time_sorted_event_table.sv */
// An insert or delete result passes from the command holding register into the
// result registers; a list passes through the holding register and the list state,
// then shows one entry a cycle, rotated out of the cell row, while the result side
// does not stall. A new item is taken only once the holding register is free.
// Reset: asynchronous, clears the count, control state and valids; slot contents
// are left as they are and only slots below the count are ever read.
// ----------------------------------------------------------------------------
// time_sorted_event_table
// Event table kept in time order by a row of shifting cells, with a
// command holding register and a registered result stage.
// ----------------------------------------------------------------------------
module time_sorted_event_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [tset_pkg::CMD_W-1:0]      command,
    input  logic [tset_pkg::HOUR_W-1:0]     hour,
    input  logic [tset_pkg::MINUTE_W-1:0]   minute,
    input  logic [tset_pkg::TAG_W-1:0]      tag,
    input  logic [tset_pkg::INDEX_W-1:0]    index,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [tset_pkg::STATUS_W-1:0]   status,
    output logic [tset_pkg::POS_W-1:0]      position,
    output logic [tset_pkg::HOUR_W-1:0]     out_hour,
    output logic [tset_pkg::MINUTE_W-1:0]   out_minute,
    output logic [tset_pkg::TAG_W-1:0]      out_tag,
    output logic [tset_pkg::TOTAL_W-1:0]    entry_total,
    output logic                            last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic                            hold_valid_reg, hold_valid_next;
    logic [tset_pkg::CMD_W-1:0]      cmd_hold_reg, cmd_hold_next;
    tset_pkg::entry_t                new_hold_reg, new_hold_next;
    logic [tset_pkg::INDEX_W-1:0]    index_hold_reg, index_hold_next;
    logic [tset_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [tset_pkg::IDX_W-1:0]      list_idx_reg, list_idx_next;

    logic                            res_valid_reg, res_valid_next;
    logic [tset_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [tset_pkg::POS_W-1:0]      position_reg, position_next;
    tset_pkg::entry_t                res_entry_reg, res_entry_next;
    logic [tset_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic                            last_reg, last_next;

    tset_pkg::cell_ctrl_t            ctrl;
    tset_pkg::entry_t                head;
    logic [tset_pkg::IDX_W-1:0]      ins_pos;
    logic                            res_free;
    logic                            list_last;

    tset_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .count     (count_reg),
        .del_index (index_hold_reg),
        .head      (head),
        .ins_pos   (ins_pos)
    );

    assign cmd_stall = hold_valid_reg;
    assign res_free  = !res_valid_reg || !res_stall;
    assign list_last = (tset_pkg::CNT_W'(list_idx_reg) + tset_pkg::CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next      = state_reg;
        hold_valid_next = hold_valid_reg;
        cmd_hold_next   = cmd_hold_reg;
        new_hold_next   = new_hold_reg;
        index_hold_next = index_hold_reg;
        count_next      = count_reg;
        list_idx_next   = list_idx_reg;
        res_valid_next  = res_valid_reg;
        status_next     = status_reg;
        position_next   = position_reg;
        res_entry_next  = res_entry_reg;
        total_next      = total_reg;
        last_next       = last_reg;
        ctrl.op         = tset_pkg::OP_HOLD;
        ctrl.new_entry  = new_hold_reg;

        // drop a result once it has been taken
        if (res_free)
        begin
            res_valid_next = 1'b0;
        end

        if (cmd_valid && !hold_valid_reg)
        begin
            hold_valid_next        = 1'b1;
            cmd_hold_next          = command;
            new_hold_next.hour     = hour;
            new_hold_next.minute   = minute;
            new_hold_next.tag      = tag;
            index_hold_next        = index;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (hold_valid_reg && res_free)
                begin
                    hold_valid_next = 1'b0;
                    res_entry_next  = '0;
                    last_next       = 1'b1;
                    total_next      = tset_pkg::TOTAL_W'(count_reg);
                    case (cmd_hold_reg)
                        tset_pkg::CMD_INSERT:
                        begin
                            res_valid_next = 1'b1;
                            if (count_reg >= tset_pkg::CNT_W'(tset_pkg::CAPACITY))
                            begin
                                status_next   = tset_pkg::STAT_FULL;
                                position_next = '0;
                            end
                            else
                            begin
                                ctrl.op       = tset_pkg::OP_INSERT;
                                count_next    = count_reg + tset_pkg::CNT_W'(1);
                                status_next   = tset_pkg::STAT_OK;
                                position_next = tset_pkg::POS_W'(ins_pos);
                                total_next    = tset_pkg::TOTAL_W'(count_next);
                            end
                        end
                        tset_pkg::CMD_DELETE:
                        begin
                            res_valid_next = 1'b1;
                            position_next  = tset_pkg::POS_W'(index_hold_reg);
                            if (tset_pkg::CMP_W'(index_hold_reg) >= tset_pkg::CMP_W'(count_reg))
                            begin
                                status_next = tset_pkg::STAT_NONE;
                            end
                            else
                            begin
                                ctrl.op     = tset_pkg::OP_DELETE;
                                count_next  = count_reg - tset_pkg::CNT_W'(1);
                                status_next = tset_pkg::STAT_OK;
                                total_next  = tset_pkg::TOTAL_W'(count_next);
                            end
                        end
                        tset_pkg::CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                                status_next    = tset_pkg::STAT_EMPTY;
                                position_next  = '0;
                            end
                            else
                            begin
                                // hold the item until every entry is out
                                hold_valid_next = 1'b1;
                                list_idx_next   = '0;
                                state_next      = ST_LIST;
                            end
                        end
                        default:
                        begin
                            hold_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_LIST:
            begin
                if (res_free)
                begin
                    ctrl.op        = tset_pkg::OP_ROTATE;
                    res_valid_next = 1'b1;
                    status_next    = tset_pkg::STAT_OK;
                    position_next  = tset_pkg::POS_W'(list_idx_reg);
                    res_entry_next = head;
                    total_next     = tset_pkg::TOTAL_W'(count_reg);
                    last_next      = list_last;
                    list_idx_next  = list_idx_reg + tset_pkg::IDX_W'(1);
                    if (list_last)
                    begin
                        hold_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hold_valid_reg <= 1'b0;
            count_reg      <= '0;
            list_idx_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            count_reg      <= count_next;
            list_idx_reg   <= list_idx_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_hold_reg   <= cmd_hold_next;
        new_hold_reg   <= new_hold_next;
        index_hold_reg <= index_hold_next;
        status_reg     <= status_next;
        position_reg   <= position_next;
        res_entry_reg  <= res_entry_next;
        total_reg      <= total_next;
        last_reg       <= last_next;
    end

    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign out_hour    = res_entry_reg.hour;
    assign out_minute  = res_entry_reg.minute;
    assign out_tag     = res_entry_reg.tag;
    assign entry_total = total_reg;
    assign last        = last_reg;

endmodule

/* rtl/core/tset_cell.sv */
// ----------------------------------------------------------------------------
// tset_cell
// One slot of the sorted row: holds an entry, shifts it to or takes it from
// a neighbour on insert, delete and rotate.
// ----------------------------------------------------------------------------
module tset_cell (
    input  logic                 clk,
    input  tset_pkg::cell_ctrl_t ctrl,
    input  tset_pkg::cell_flags_t flags,
    input  tset_pkg::entry_t     left_entry,
    input  tset_pkg::entry_t     right_entry,
    input  tset_pkg::entry_t     head_entry,
    input  logic                 left_goes,
    output tset_pkg::entry_t     entry,
    output logic                 goes
);

    tset_pkg::entry_t entry_reg;
    tset_pkg::entry_t entry_next;

    // Free slots and later entries sit at or after the insert point
    assign goes  = !flags.occupied || tset_pkg::later(entry_reg, ctrl.new_entry);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            tset_pkg::OP_INSERT:
            begin
                if (goes)
                begin
                    entry_next = left_goes ? left_entry : ctrl.new_entry;
                end
            end
            tset_pkg::OP_DELETE:
            begin
                if (flags.del_shift)
                begin
                    entry_next = right_entry;
                end
            end
            tset_pkg::OP_ROTATE:
            begin
                // wrap the head round to the tail so the list comes back intact
                if (flags.tail)
                begin
                    entry_next = head_entry;
                end
                else if (flags.occupied)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/tset_chain.sv */
// ----------------------------------------------------------------------------
// tset_chain
// Row of slot cells with neighbour links, per-slot flags and the insert
// position encoder.
// ----------------------------------------------------------------------------
module tset_chain (
    input  logic                               clk,
    input  tset_pkg::cell_ctrl_t               ctrl,
    input  logic [tset_pkg::CNT_W-1:0]         count,
    input  logic [tset_pkg::INDEX_W-1:0]       del_index,
    output tset_pkg::entry_t                   head,
    output logic [tset_pkg::IDX_W-1:0]         ins_pos
);

    tset_pkg::entry_t            entries [tset_pkg::CAPACITY];
    logic [tset_pkg::CAPACITY-1:0] goes;
    logic [tset_pkg::CAPACITY-1:0] first_goes;

    genvar i;
    generate
        for (i = 0; i < tset_pkg::CAPACITY; i++)
        begin : g_cell
            tset_pkg::cell_flags_t flags;
            tset_pkg::entry_t      left_entry;
            tset_pkg::entry_t      right_entry;
            logic                  left_goes;

            assign flags.occupied  = tset_pkg::CNT_W'(i) < count;
            assign flags.tail      = tset_pkg::CNT_W'(i + 1) == count;
            assign flags.del_shift = tset_pkg::CMP_W'(i) >= tset_pkg::CMP_W'(del_index);

            if (i == 0)
            begin : g_first
                assign left_entry = '0;
                assign left_goes  = 1'b0;
            end
            else
            begin : g_inner
                assign left_entry = entries[i-1];
                assign left_goes  = goes[i-1];
            end

            if (i == tset_pkg::CAPACITY - 1)
            begin : g_end
                assign right_entry = entries[i];
            end
            else
            begin : g_mid
                assign right_entry = entries[i+1];
            end

            assign first_goes[i] = goes[i] && !left_goes;

            tset_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .flags       (flags),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .head_entry  (entries[0]),
                .left_goes   (left_goes),
                .entry       (entries[i]),
                .goes        (goes[i])
            );
        end
    endgenerate

    assign head = entries[0];

    // At most one cell marks the insert point, and one does while a slot is free; encode it
    always_comb
    begin
        ins_pos = '0;
        for (int k = 0; k < tset_pkg::CAPACITY; k++)
        begin
            if (first_goes[k])
            begin
                ins_pos = ins_pos | tset_pkg::IDX_W'(k);
            end
        end
    end

endmodule

/* rtl/core/tset_checker.sv */
// ----------------------------------------------------------------------------
// tset_checker
// Port-level checks on the result channel of the event table.
// ----------------------------------------------------------------------------
`include "time_sorted_event_table_macros.svh"

module tset_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_valid,
    input  logic                            res_stall,
    input  logic [tset_pkg::STATUS_W-1:0]   status,
    input  logic [tset_pkg::POS_W-1:0]      position,
    input  logic [tset_pkg::TOTAL_W-1:0]    entry_total,
    input  logic                            last
);

    `TSET_NEXT(a_res_held, res_valid && res_stall, res_valid, "result dropped while stalled")

    `TSET_HOLDS(a_full_total, res_valid && (status == tset_pkg::STAT_FULL), last && (entry_total == tset_pkg::TOTAL_W'(tset_pkg::CAPACITY)), "full refusal with table not full")

    `TSET_HOLDS(a_multi_ok, res_valid && !last, status == tset_pkg::STAT_OK, "non-final result with error status")

    `TSET_HOLDS(a_empty, res_valid && (status == tset_pkg::STAT_EMPTY), last && (entry_total == '0) && (position == '0), "empty status with entries held")

endmodule

bind time_sorted_event_table tset_checker u_tset_checker (.*);

/* tb/sv/time_sorted_event_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_sorted_event_table_tb
// Drives insert, delete, list and spare commands into the event table. A
// table model inside the bench predicts every result: time order, arrival
// order on equal times, full, missing and empty status. Each result is
// compared field by field, and both handshakes idle at random.
// ----------------------------------------------------------------------------
module time_sorted_event_table_tb;

    import tset_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE   = 2'd3;
    localparam int               QUIET_LIMIT = 1000;
    localparam int               TAIL_CYCLES = 40;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [TAG_W-1:0]    tag;
        logic [TOTAL_W-1:0]  total;
        logic                last;
    } table_reply_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cmd_valid   = 1'b0;
    logic                cmd_stall;
    logic [CMD_W-1:0]    command     = '0;
    logic [HOUR_W-1:0]   hour        = '0;
    logic [MINUTE_W-1:0] minute      = '0;
    logic [TAG_W-1:0]    tag         = '0;
    logic [INDEX_W-1:0]  index       = '0;
    logic                res_valid;
    logic                res_stall   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [HOUR_W-1:0]   out_hour;
    logic [MINUTE_W-1:0] out_minute;
    logic [TAG_W-1:0]    out_tag;
    logic [TOTAL_W-1:0]  entry_total;
    logic                last;

    // Table model
    logic [HOUR_W-1:0]   model_hour   [CAPACITY];
    logic [MINUTE_W-1:0] model_minute [CAPACITY];
    logic [TAG_W-1:0]    model_tag    [CAPACITY];
    int                  table_count  = 0;
    table_reply_t        table_replies[$];

    int mismatch_count = 0;
    int idle_pct       = 10;

    time_sorted_event_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .command     (command),
        .hour        (hour),
        .minute      (minute),
        .tag         (tag),
        .index       (index),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .status      (status),
        .position    (position),
        .out_hour    (out_hour),
        .out_minute  (out_minute),
        .out_tag     (out_tag),
        .entry_total (entry_total),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    function automatic void push_reply(logic [STATUS_W-1:0] st, int pos,
                                       logic [HOUR_W-1:0] h, logic [MINUTE_W-1:0] m,
                                       logic [TAG_W-1:0] t, logic fin);
        table_reply_t r;
        r.status   = st;
        r.position = pos[POS_W-1:0];
        r.hour     = h;
        r.minute   = m;
        r.tag      = t;
        r.total    = table_count[TOTAL_W-1:0];
        r.last     = fin;
        table_replies.push_back(r);
    endfunction

    // True when the held slot is strictly later than the given time.
    function automatic logic slot_is_later(int slot, logic [HOUR_W-1:0] h,
                                           logic [MINUTE_W-1:0] m);
        return (model_hour[slot] > h) || (model_hour[slot] == h && model_minute[slot] > m);
    endfunction

    function automatic void apply_table_command(logic [CMD_W-1:0] cmd,
                                                logic [HOUR_W-1:0] h,
                                                logic [MINUTE_W-1:0] m,
                                                logic [TAG_W-1:0] t,
                                                logic [INDEX_W-1:0] idx);
        int pos;
        pos = 0;
        case (cmd)
            CMD_INSERT:
            begin
                if (table_count >= CAPACITY)
                begin
                    push_reply(STAT_FULL, 0, '0, '0, '0, 1'b1);
                end
                else
                begin
                    // place after every entry that is not later
                    while (pos < table_count && !slot_is_later(pos, h, m))
                        pos++;
                    for (int i = table_count; i > pos; i--)
                    begin
                        model_hour[i]   = model_hour[i-1];
                        model_minute[i] = model_minute[i-1];
                        model_tag[i]    = model_tag[i-1];
                    end
                    model_hour[pos]   = h;
                    model_minute[pos] = m;
                    model_tag[pos]    = t;
                    table_count++;
                    push_reply(STAT_OK, pos, '0, '0, '0, 1'b1);
                end
            end
            CMD_DELETE:
            begin
                if (int'(idx) >= table_count)
                begin
                    push_reply(STAT_NONE, int'(idx), '0, '0, '0, 1'b1);
                end
                else
                begin
                    for (int i = int'(idx); i + 1 < table_count; i++)
                    begin
                        model_hour[i]   = model_hour[i+1];
                        model_minute[i] = model_minute[i+1];
                        model_tag[i]    = model_tag[i+1];
                    end
                    table_count--;
                    push_reply(STAT_OK, int'(idx), '0, '0, '0, 1'b1);
                end
            end
            CMD_LIST:
            begin
                if (table_count == 0)
                    push_reply(STAT_EMPTY, 0, '0, '0, '0, 1'b1);
                else
                    for (int i = 0; i < table_count; i++)
                        push_reply(STAT_OK, i, model_hour[i], model_minute[i],
                                   model_tag[i], i + 1 == table_count);
            end
            default:
            begin
                // spare code: no result, no change
            end
        endcase
    endfunction

    task automatic send_item(logic [CMD_W-1:0] ev_cmd, logic [HOUR_W-1:0] ev_hour,
                             logic [MINUTE_W-1:0] ev_minute, logic [TAG_W-1:0] ev_tag,
                             logic [INDEX_W-1:0] ev_index);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command   <= ev_cmd;
        hour      <= ev_hour;
        minute    <= ev_minute;
        tag       <= ev_tag;
        index     <= ev_index;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        apply_table_command(ev_cmd, ev_hour, ev_minute, ev_tag, ev_index);
    endtask

    // Mostly legal times, clustered so that equal times turn up often.
    function automatic logic [HOUR_W-1:0] pick_hour();
        if ($urandom_range(0, 9) == 0)
            return HOUR_W'($urandom_range(0, 31));
        if ($urandom_range(0, 3) == 0)
            return 5'd12;
        return HOUR_W'($urandom_range(0, 23));
    endfunction

    function automatic logic [MINUTE_W-1:0] pick_minute();
        if ($urandom_range(0, 9) == 0)
            return MINUTE_W'($urandom_range(0, 63));
        if ($urandom_range(0, 3) == 0)
            return 6'd30;
        return MINUTE_W'($urandom_range(0, 59));
    endfunction

    task automatic send_insert();
        send_item(CMD_INSERT, pick_hour(), pick_minute(), TAG_W'($urandom),
                  INDEX_W'($urandom));
    endtask

    task automatic send_delete(logic [INDEX_W-1:0] idx);
        send_item(CMD_DELETE, pick_hour(), pick_minute(), TAG_W'($urandom), idx);
    endtask

    task automatic send_list();
        send_item(CMD_LIST, pick_hour(), pick_minute(), TAG_W'($urandom),
                  INDEX_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_table();
        send_list();
        send_delete(4'd0);
        send_delete(4'd15);
        send_item(CMD_SPARE, 5'd31, 6'd63, 16'hFFFF, 4'hF);
        send_list();
    endtask

    task automatic test_edge_times();
        send_item(CMD_INSERT, 5'd23, 6'd59, 16'hFFFF, 4'h0);
        send_item(CMD_INSERT, 5'd0,  6'd0,  16'h0000, 4'hF);
        send_item(CMD_INSERT, 5'd12, 6'd30, 16'h1111, 4'h5);
        // equal time goes after the earlier arrival
        send_item(CMD_INSERT, 5'd12, 6'd30, 16'h2222, 4'hA);
        // out of range times sort by their numeric value
        send_item(CMD_INSERT, 5'd31, 6'd63, TAG_W'($urandom), 4'h3);
        send_item(CMD_INSERT, 5'd12, 6'd29, 16'h5A5A, 4'hC);
        send_list();
        send_delete(4'd0);
        send_delete(INDEX_W'(table_count - 1));
        send_delete(4'd15);
        send_list();
    endtask

    task automatic test_fill_and_drain();
        repeat (3)
        begin
            while (table_count < CAPACITY)
                send_insert();
            repeat ($urandom_range(1, 3))
                send_insert();
            send_list();
            while (table_count > 0)
                send_delete(INDEX_W'($urandom_range(0, table_count - 1)));
            send_delete(INDEX_W'($urandom_range(0, 15)));
            send_list();
        end
    endtask

    task automatic test_random_mix(int count);
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_insert();
            else if (pick < 75)
                send_delete(INDEX_W'((table_count > 0 && $urandom_range(0, 1)) ?
                            $urandom_range(0, table_count - 1) : $urandom_range(0, 15)));
            else if (pick < 93)
                send_list();
            else
                send_item(CMD_SPARE, HOUR_W'($urandom), MINUTE_W'($urandom),
                          TAG_W'($urandom), INDEX_W'($urandom));
        end
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        test_random_mix(100);
        idle_pct = 10;
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        table_reply_t exp_r;
        if (rst_n && res_valid && !res_stall)
        begin
            if (table_replies.size() == 0)
            begin
                $error("result with nothing expected: status %0d position %0d",
                       status, position);
                mismatch_count++;
            end
            else
            begin
                exp_r = table_replies.pop_front();
                compare_field("status",      32'(exp_r.status),   32'(status));
                compare_field("position",    32'(exp_r.position), 32'(position));
                compare_field("out_hour",    32'(exp_r.hour),     32'(out_hour));
                compare_field("out_minute",  32'(exp_r.minute),   32'(out_minute));
                compare_field("out_tag",     32'(exp_r.tag),      32'(out_tag));
                compare_field("entry_total", 32'(exp_r.total),    32'(entry_total));
                compare_field("last",        32'(exp_r.last),     32'(last));
            end
        end
        res_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    // Abort when neither side moves an item for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_edge_times();
        test_fill_and_drain();
        test_random_mix(200);
        test_back_to_back();

        cmd_valid <= 1'b0;
        while (table_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
